### rtl/core/mac_pkg.sv
// Shared types, widths and codes of the moving average crossover block.
// No dependencies; every other file imports this package.
package mac_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PRICE_BITS = 32;
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int SUM_W      = PRICE_BITS + PTR_W;
  localparam int STEP_W     = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = CFG_IDX_W'(1);

  localparam logic [WIN_W-1:0] SHORT_WINDOW_RST = WIN_W'(5);
  localparam logic [WIN_W-1:0] LONG_WINDOW_RST  = WIN_W'(20);

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_e;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_SHORT,
    ST_RD_LONG,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } state_e;

  function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    if (w == '0) begin
      r = WIN_W'(1);
    end else if (w > WIN_W'(MAX_WINDOW)) begin
      r = WIN_W'(MAX_WINDOW);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

### rtl/core/mac_div.sv
// Bit-serial restoring divider: one quotient bit per cycle over the SUM_W-bit dividend.
// Depends on mac_pkg for the sum, window and step counter widths.
module mac_div import mac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SUM_W-1:0]      dividend_i,
  input  logic [WIN_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [PRICE_BITS-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  work_q, work_d;
  logic [WIN_W-1:0]  rem_q, rem_d;
  logic [WIN_W-1:0]  div_q, div_d;
  logic [WIN_W:0]    trial;
  logic [WIN_W:0]    diff;

  assign trial = {rem_q, work_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    work_d = work_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      work_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[WIN_W]) begin
        rem_d  = diff[WIN_W-1:0];
        work_d = {work_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[WIN_W-1:0];
        work_d = {work_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = work_q[PRICE_BITS-1:0];

endmodule

### rtl/core/mac_hist.sv
// Price history memory: one write port, one read port with registered data.
// Depends on mac_pkg for depth and price width.
module mac_hist import mac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [PTR_W-1:0]      waddr_i,
  input  logic [PRICE_BITS-1:0] wdata_i,
  input  logic [PTR_W-1:0]      raddr_i,
  output logic [PRICE_BITS-1:0] rdata_o
);

  logic [PRICE_BITS-1:0] mem [MAX_WINDOW];
  logic [PRICE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/moving_average_crossover.sv
// Top level of the moving average crossover detector.
// Depends on mac_pkg, mac_hist and mac_div.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, price_i) takes one price sample
//   per request. Output channel (out_valid_o, out_stall_i, signal_o,
//   short_average_o, long_average_o) returns one result per request.
//   Configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes short_window (index 0) or long_window (index 1); such a write
//   restarts the stream. Other indexes are taken and ignored.
// Flow: a taken request goes through the short and long history reads on the
//   single memory read port, the sum update, the two bit-serial dividers that
//   run side by side (one quotient bit per cycle over 40 bits) and the output
//   load; no new request is taken until its result has been loaded.
// Reset: windows return to 5 and 20, the stream restarts, no result pending.
// Receiver stall: the finished result waits in the output register; the next
//   request is still taken and computed, and its result waits until the
//   output register is free.
module moving_average_crossover import mac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PRICE_BITS-1:0] price_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            signal_o,
  output logic [PRICE_BITS-1:0] short_average_o,
  output logic [PRICE_BITS-1:0] long_average_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [WIN_W-1:0]      cfg_data_i
);

  state_e                state_q, state_d;
  logic [WIN_W-1:0]      short_win_q, short_win_d;
  logic [WIN_W-1:0]      long_win_q, long_win_d;
  logic [PTR_W-1:0]      wp_q, wp_d;
  logic [WIN_W-1:0]      count_q, count_d;
  logic [SUM_W-1:0]      short_sum_q, short_sum_d;
  logic [SUM_W-1:0]      long_sum_q, long_sum_d;
  sign_e                 prev_sign_q, prev_sign_d;
  logic [PRICE_BITS-1:0] price_q;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            signal_q;
  logic [PRICE_BITS-1:0] short_avg_q, long_avg_q;

  logic [WIN_W-1:0]      ws_c, wl_c, ws, wl, ds, dl;
  logic                  in_accept, cfg_accept, cfg_restart, out_load;
  logic                  hist_we;
  logic [PTR_W-1:0]      hist_raddr;
  logic [PRICE_BITS-1:0] hist_rdata;
  logic                  div_start, div_s_done, div_l_done;
  logic [PRICE_BITS-1:0] quot_s, quot_l;
  sign_e                 sign_c;
  signal_e               signal_c;

  assign ws_c = clamp_window(short_win_q);
  assign wl_c = clamp_window(long_win_q);
  assign ws   = (ws_c > wl_c) ? wl_c : ws_c;
  assign wl   = (ws_c > wl_c) ? ws_c : wl_c;
  assign ds   = (count_q < ws) ? count_q : ws;
  assign dl   = (count_q < wl) ? count_q : wl;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_accept &&
                       (cfg_index_i == REG_SHORT_WINDOW || cfg_index_i == REG_LONG_WINDOW);

  mac_hist u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (wp_q),
    .wdata_i (price_q),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  mac_div u_div_short (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (short_sum_q),
    .divisor_i  (ds),
    .done_o     (div_s_done),
    .quot_o     (quot_s)
  );

  mac_div u_div_long (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (long_sum_q),
    .divisor_i  (dl),
    .done_o     (div_l_done),
    .quot_o     (quot_l)
  );

  always_comb begin
    if (quot_l > quot_s) begin
      sign_c = SIGN_POS;
    end else if (quot_l < quot_s) begin
      sign_c = SIGN_NEG;
    end else begin
      sign_c = SIGN_ZERO;
    end
    if (sign_c == SIGN_NEG && prev_sign_q == SIGN_POS) begin
      signal_c = SIG_BUY;
    end else if (sign_c == SIGN_POS && prev_sign_q == SIGN_NEG) begin
      signal_c = SIG_SELL;
    end else begin
      signal_c = SIG_NONE;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_accept) state_d = ST_RD_SHORT;
      ST_RD_SHORT: state_d = ST_RD_LONG;
      ST_RD_LONG:  state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_START;
      ST_START:    state_d = ST_DIVIDE;
      ST_DIVIDE:   if (div_s_done && div_l_done) state_d = ST_OUTPUT;
      ST_OUTPUT:   if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    hist_we     = 1'b0;
    hist_raddr  = wp_q - ws[PTR_W-1:0];
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = cfg_valid_i;
        cfg_ready_o = 1'b1;
      end
      ST_RD_SHORT: hist_raddr = wp_q - ws[PTR_W-1:0];
      ST_RD_LONG:  hist_raddr = wp_q - wl[PTR_W-1:0];
      ST_UPDATE:   hist_we = 1'b1;
      ST_START:    div_start = 1'b1;
      ST_DIVIDE:   ;
      ST_OUTPUT:   out_load = !out_valid_q || !out_stall_i;
      default:     ;
    endcase
  end

  // datapath registers
  always_comb begin
    short_win_d = short_win_q;
    long_win_d  = long_win_q;
    wp_d        = wp_q;
    count_d     = count_q;
    short_sum_d = short_sum_q;
    long_sum_d  = long_sum_q;
    prev_sign_d = prev_sign_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_accept && cfg_index_i == REG_SHORT_WINDOW) begin
      short_win_d = cfg_data_i;
    end
    if (cfg_accept && cfg_index_i == REG_LONG_WINDOW) begin
      long_win_d = cfg_data_i;
    end
    if (cfg_restart) begin
      wp_d        = '0;
      count_d     = '0;
      short_sum_d = '0;
      long_sum_d  = '0;
      prev_sign_d = SIGN_ZERO;
    end
    if (in_accept) begin
      short_sum_d = short_sum_q + SUM_W'(price_i);
      long_sum_d  = long_sum_q + SUM_W'(price_i);
    end
    if (state_q == ST_RD_LONG && count_q >= ws) begin
      short_sum_d = short_sum_q - SUM_W'(hist_rdata);
    end
    if (state_q == ST_UPDATE) begin
      if (count_q >= wl) begin
        long_sum_d = long_sum_q - SUM_W'(hist_rdata);
      end
      wp_d = wp_q + PTR_W'(1);
      if (count_q < WIN_W'(MAX_WINDOW)) begin
        count_d = count_q + WIN_W'(1);
      end
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      prev_sign_d = sign_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      short_win_q <= SHORT_WINDOW_RST;
      long_win_q  <= LONG_WINDOW_RST;
      wp_q        <= '0;
      count_q     <= '0;
      short_sum_q <= '0;
      long_sum_q  <= '0;
      prev_sign_q <= SIGN_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      short_win_q <= short_win_d;
      long_win_q  <= long_win_d;
      wp_q        <= wp_d;
      count_q     <= count_d;
      short_sum_q <= short_sum_d;
      long_sum_q  <= long_sum_d;
      prev_sign_q <= prev_sign_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      price_q <= price_i;
    end
    if (out_load) begin
      signal_q    <= signal_c;
      short_avg_q <= quot_s;
      long_avg_q  <= quot_l;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign signal_o        = signal_q;
  assign short_average_o = short_avg_q;
  assign long_average_o  = long_avg_q;

endmodule

### rtl/core/mac_chk.sv
// Port-level checks on the moving average crossover top level, bound to it.
// Depends on mac_pkg for widths and signal codes.
module mac_chk import mac_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            signal_o,
  input logic [PRICE_BITS-1:0] short_average_o,
  input logic [PRICE_BITS-1:0] long_average_o,
  input logic                  cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(signal_o) && $stable(short_average_o) &&
                                   $stable(long_average_o))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("request taken while previous one is in progress");

  a_cross_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && signal_o != SIG_NONE |-> short_average_o != long_average_o)
    else $error("crossing reported with equal averages");

endmodule

bind moving_average_crossover mac_chk u_mac_chk (.*);
